>>> rtl/mbd_pkg.sv
`timescale 1ns / 1ps
// mbd_pkg: shared types and constants of the multi-button debouncer.
// No dependencies; imported by mbd_cell and multi_button_debouncer_top.
package mbd_pkg;

  localparam int unsigned IDX_W       = 3;   // report_index / button_index width
  localparam int unsigned CNT_W       = 8;   // tick counter and timeout width
  localparam int unsigned CFG_W       = 8;   // widest config register
  localparam int unsigned CFG_ADDR_W  = 1;   // two registers
  localparam int unsigned MAX_EN_BTN  = 8;   // buttons reachable by enable_mask
  localparam int unsigned S_DATA_W    = 16;  // button_index + pin_levels, byte padded
  localparam int unsigned M_DATA_W    = 8;   // report_index + pressed, byte padded

  localparam logic [CNT_W-1:0] TIMEOUT_RST = 8'd5;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_ENABLE_MASK   = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT_TICKS = 1'b1;

  // request kinds (tuser)
  localparam logic REQ_EDGE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // last reported state codes
  typedef enum logic [1:0] {
    LR_NONE     = 2'd0,
    LR_PRESSED  = 2'd1,
    LR_RELEASED = 2'd2
  } last_rep_e;

  // number of reports a cell still owes after a tick
  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_ONE  = 2'd1,
    PEND_TWO  = 2'd2
  } pend_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_SWEEP = 1'b1
  } state_e;

  // per-cell controls driven by the top level
  typedef struct packed {
    logic             edge_hit;  // edge item addressed to this button
    logic             tick;      // tick item accepted
    logic             en;        // button registered
    logic             pin;       // pin level on this tick
    logic             take;      // head report consumed this cycle
    logic [CNT_W-1:0] timeout;
  } cell_ctrl_t;

  // per-cell status toward the top level and neighbor
  typedef struct packed {
    logic tok;       // cell holds the sweep token
    logic pass;      // token leaves this cell this cycle
    logic pend_nz;   // reports outstanding
    logic pend_one;  // exactly one report outstanding
    logic pressed;   // value of the next report
  } cell_stat_t;

endpackage

>>> rtl/mbd_cell.sv
`timescale 1ns / 1ps
// mbd_cell: state of one button (armed, tick count, last report, pending reports)
// plus its slot of the report token chain. Depends on mbd_pkg.
module mbd_cell
  import mbd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       tok_i,   // token handed over from the lower neighbor
  output cell_stat_t stat_o
);

  logic             armed_q, armed_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  last_rep_e        lr_q, lr_d;
  pend_e            pend_q, pend_d;
  logic             pr_q, pr_d;
  logic             tok_q, tok_d;

  logic [CNT_W-1:0] cnt_inc;
  logic             counting;
  logic             fire;
  last_rep_e        st;
  logic             pass;

  // 8-bit wrap makes a zero timeout behave as 256
  assign cnt_inc  = cnt_q + 1'b1;
  assign counting = ctrl_i.tick && armed_q && ctrl_i.en;
  assign fire     = counting && (cnt_inc == ctrl_i.timeout);
  assign st       = ctrl_i.pin ? LR_PRESSED : LR_RELEASED;
  assign pass     = tok_q && (pend_q == PEND_NONE);

  always_comb begin
    armed_d = armed_q;
    cnt_d   = cnt_q;
    lr_d    = lr_q;
    pend_d  = pend_q;
    pr_d    = pr_q;
    if (ctrl_i.edge_hit && ctrl_i.en) begin
      armed_d = 1'b1;
      cnt_d   = '0;
    end else if (fire) begin
      armed_d = 1'b0;
      cnt_d   = '0;
      lr_d    = st;
      pr_d    = ctrl_i.pin;
      // same state again: a pair of edges was missed
      pend_d  = (lr_q == st) ? PEND_TWO : PEND_ONE;
    end else if (counting) begin
      cnt_d = cnt_inc;
    end else if (ctrl_i.take) begin
      pend_d = (pend_q == PEND_TWO) ? PEND_ONE : PEND_NONE;
    end
  end

  always_comb begin
    if (tok_i) begin
      tok_d = 1'b1;
    end else if (pass) begin
      tok_d = 1'b0;
    end else begin
      tok_d = tok_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      cnt_q   <= '0;
      lr_q    <= LR_NONE;
      pend_q  <= PEND_NONE;
      tok_q   <= 1'b0;
    end else begin
      armed_q <= armed_d;
      cnt_q   <= cnt_d;
      lr_q    <= lr_d;
      pend_q  <= pend_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pr_q <= pr_d;
  end

  assign stat_o.tok      = tok_q;
  assign stat_o.pass     = pass;
  assign stat_o.pend_nz  = (pend_q != PEND_NONE);
  assign stat_o.pend_one = (pend_q == PEND_ONE);
  // opposite state goes out first when two reports are owed
  assign stat_o.pressed  = pr_q ^ (pend_q == PEND_TWO);

endmodule

>>> rtl/multi_button_debouncer_top.sv
`timescale 1ns / 1ps
// multi_button_debouncer_top: row of mbd_cell instances, sweep control and
// output register. Depends on mbd_pkg and mbd_cell.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+-----------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready | tuser: req_type; tdata: index, pin_levels
//  m_axis   | out | m_axis_tvalid/tready | tdata: report_index, pressed; tlast: last
//  cfg      | in  | cfg_we_i             | cfg_addr_i, cfg_wdata_i
//
// Edge items leave the input ready. A tick item updates every cell in the cycle
// it is accepted, then a token walks the cell row one cell per cycle and stops at
// a cell for each report it owes, and for as long as m_axis stalls.
// Reset clears all button state and loads enable_mask = 0, timeout_ticks = 5.
// Input is taken only between sweeps; a finished report may still wait in the
// output register while the next item is accepted.
module multi_button_debouncer_top
  import mbd_pkg::*;
#(
  parameter int unsigned NUM_BUTTONS = 8  // 1..32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_DATA_W-1:0]   s_axis_tdata,   // [2:0] button_index, [10:3] pin_levels
  input  logic                  s_axis_tuser,   // [0] req_type
  // report stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_DATA_W-1:0]   m_axis_tdata,   // [2:0] report_index, [3] pressed
  output logic                  m_axis_tlast,   // last
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i
);

  // ---------------- configuration registers
  logic [CFG_W-1:0] enable_q;
  logic [CNT_W-1:0] timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= '0;
      timeout_q <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_ENABLE_MASK:   enable_q  <= cfg_wdata_i;
        REG_TIMEOUT_TICKS: timeout_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------- input decode
  logic                  in_acc;
  logic                  tick_acc;
  logic                  edge_acc;
  logic [IDX_W-1:0]      in_idx;
  logic [MAX_EN_BTN-1:0] in_pins;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign tick_acc = in_acc && (s_axis_tuser == REQ_TICK);
  assign edge_acc = in_acc && (s_axis_tuser == REQ_EDGE);
  assign in_idx   = s_axis_tdata[IDX_W-1:0];
  assign in_pins  = s_axis_tdata[IDX_W +: MAX_EN_BTN];

  // ---------------- sweep control
  state_e state_q, state_d;
  logic   load;      // head report moves into the output register
  logic   head_take; // token cell has a report to hand out
  logic   sweep_done;

  cell_ctrl_t ctrl [NUM_BUTTONS];
  cell_stat_t stat [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] tok_vec, pend_vec, one_vec, pr_vec;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (tick_acc)   state_d = ST_SWEEP;
      ST_SWEEP: if (sweep_done) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    head_take     = 1'b0;
    case (state_q)
      ST_IDLE:  s_axis_tready = 1'b1;
      ST_SWEEP: head_take     = |(tok_vec & pend_vec);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign load       = head_take && (!m_axis_tvalid || m_axis_tready);
  assign sweep_done = stat[NUM_BUTTONS-1].pass;

  // ---------------- cell row
  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_cell
    localparam logic REACH = (g < MAX_EN_BTN);
    logic tok_in;

    if (g == 0) begin : g_head
      assign tok_in = tick_acc;
    end else begin : g_link
      assign tok_in = stat[g-1].pass;
    end

    if (REACH) begin : g_reach
      assign ctrl[g].edge_hit = edge_acc && (in_idx == IDX_W'(g));
      assign ctrl[g].en       = enable_q[g];
      assign ctrl[g].pin      = in_pins[g];
    end else begin : g_unreach
      // buttons past the mask width can never be registered
      assign ctrl[g].edge_hit = 1'b0;
      assign ctrl[g].en       = 1'b0;
      assign ctrl[g].pin      = 1'b0;
    end
    assign ctrl[g].tick    = tick_acc;
    assign ctrl[g].take    = load && stat[g].tok;
    assign ctrl[g].timeout = timeout_q;

    mbd_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl[g]),
      .tok_i  (tok_in),
      .stat_o (stat[g])
    );

    assign tok_vec[g]  = stat[g].tok;
    assign pend_vec[g] = stat[g].pend_nz;
    assign one_vec[g]  = stat[g].pend_one;
    assign pr_vec[g]   = stat[g].pressed;
  end

  // ---------------- head report select (token is one-hot during a sweep)
  logic [IDX_W-1:0] head_idx;
  logic             head_pr;
  logic             head_last;

  always_comb begin
    head_idx = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (tok_vec[i]) head_idx = head_idx | IDX_W'(i);
    end
  end

  assign head_pr   = |(tok_vec & pr_vec);
  // cells below the token are drained, so any other pending cell lies above it
  assign head_last = |(tok_vec & one_vec) && !(|(pend_vec & ~tok_vec));

  // ---------------- output register
  logic             m_valid_q;
  logic [IDX_W-1:0] m_idx_q;
  logic             m_pr_q;
  logic             m_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      m_idx_q  <= head_idx;
      m_pr_q   <= head_pr;
      m_last_q <= head_last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(M_DATA_W-IDX_W-1){1'b0}}, m_pr_q, m_idx_q};
  assign m_axis_tlast  = m_last_q;

  // ---------------- assertions
  a_tok_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vec))
    else $error("more than one cell holds the sweep token");

  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (pend_vec == '0) && (tok_vec == '0))
    else $error("input ready while reports are outstanding");

  a_tick_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_acc |=> tok_vec[0] && (state_q == ST_SWEEP))
    else $error("tick did not start a sweep at the first cell");

  a_load_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (state_q == ST_SWEEP) && $onehot(tok_vec))
    else $error("report loaded without a unique token holder");

endmodule

>>> test/tb_multi_button_debouncer_top.sv
`timescale 1ns / 1ps
// tb_multi_button_debouncer_top: self-checking testbench for the multi-button debouncer.
// Depends on mbd_pkg and multi_button_debouncer_top; a scoreboard class predicts the reports.
module tb_multi_button_debouncer_top
  import mbd_pkg::*;
;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SETTLE_CYCLES = 40;   // covers a full sweep with nothing due
  localparam int unsigned HOLD_CYCLES = 300;    // long receiver hold-off

  // one report on the m_axis side
  typedef struct {
    logic [IDX_W-1:0] index;
    logic             pressed;
    logic             is_last;
  } report_t;

  // Tracks armed flags, tick counts and last reported states, and keeps the
  // reports still owed by the block in arrival order.
  class debounce_scoreboard;
    logic [7:0]       enable_mask;
    logic [CNT_W-1:0] timeout_ticks;
    bit               armed[8];
    logic [CNT_W-1:0] tick_count[8];
    last_rep_e        last_rep[8];
    report_t          owed_reports[$];
    int unsigned      errors;

    function new();
      enable_mask   = '0;
      timeout_ticks = TIMEOUT_RST;
      for (int i = 0; i < 8; i++) begin
        armed[i]      = 1'b0;
        tick_count[i] = '0;
        last_rep[i]   = LR_NONE;
      end
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_W-1:0] data);
      case (addr)
        REG_ENABLE_MASK:   enable_mask = data;
        REG_TIMEOUT_TICKS: timeout_ticks = data;
        default: ;
      endcase
    endfunction

    // note one accepted item and queue the reports it causes
    function void note_item(logic req_type, logic [IDX_W-1:0] idx, logic [7:0] levels);
      report_t   batch[$];
      report_t   rep;
      last_rep_e st;
      if (req_type == REQ_EDGE) begin
        if (enable_mask[idx]) begin
          armed[idx]      = 1'b1;
          tick_count[idx] = '0;
        end
        return;
      end
      for (int i = 0; i < 8; i++) begin
        if (!armed[i] || !enable_mask[i]) continue;
        tick_count[i] = tick_count[i] + 1'b1;   // wraps, so a zero timeout means 256
        if (tick_count[i] != timeout_ticks) continue;
        armed[i]      = 1'b0;
        tick_count[i] = '0;
        st = levels[i] ? LR_PRESSED : LR_RELEASED;
        rep.index   = i[IDX_W-1:0];
        rep.is_last = 1'b0;
        if (last_rep[i] == st) begin
          // same state as last time: a press/release pair went unseen
          rep.pressed = ~levels[i];
          batch.push_back(rep);
        end
        last_rep[i] = st;
        rep.pressed = levels[i];
        batch.push_back(rep);
      end
      foreach (batch[j]) begin
        rep = batch[j];
        rep.is_last = (j == batch.size() - 1);
        owed_reports.push_back(rep);
      end
    endfunction

    function void check_report(logic [IDX_W-1:0] idx, logic pressed, logic is_last);
      report_t exp_rep;
      if (owed_reports.size() == 0) begin
        $error("unexpected report: index %0d pressed %0b last %0b", idx, pressed, is_last);
        errors++;
        return;
      end
      exp_rep = owed_reports.pop_front();
      if (idx !== exp_rep.index) begin
        $error("report_index: expected %0d, got %0d", exp_rep.index, idx);
        errors++;
      end
      if (pressed !== exp_rep.pressed) begin
        $error("pressed: expected %0b, got %0b", exp_rep.pressed, pressed);
        errors++;
      end
      if (is_last !== exp_rep.is_last) begin
        $error("last: expected %0b, got %0b", exp_rep.is_last, is_last);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return owed_reports.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [S_DATA_W-1:0]   s_axis_tdata;   // [2:0] button_index, [10:3] pin_levels
  logic                  s_axis_tuser;   // [0] req_type
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [M_DATA_W-1:0]   m_axis_tdata;   // [2:0] report_index, [3] pressed
  logic                  m_axis_tlast;
  logic                  cfg_we_i;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [CFG_W-1:0]      cfg_wdata_i;

  debounce_scoreboard sb = new();
  int unsigned        hold_reqs = 0;   // main flow bumps this to ask for a long hold-off
  int unsigned        cycle_count;

  multi_button_debouncer_top #(
    .NUM_BUTTONS(8)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog: ends a hung run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Report receiver: checks every accepted report and varies tready by a randomly
  // redrawn mode; a hold request forces a long stall on top.
  initial begin
    int unsigned rcv_cycle;
    int unsigned hold_left;
    int unsigned hold_seen;
    int unsigned mode;
    logic        rdy;
    rcv_cycle     = 0;
    hold_left     = 0;
    hold_seen     = 0;
    mode          = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready)
        sb.check_report(m_axis_tdata[2:0], m_axis_tdata[3], m_axis_tlast);
      rcv_cycle++;
      if (rcv_cycle % 50 == 0) mode = $urandom_range(0, 3);
      if (hold_reqs != hold_seen) begin
        hold_left = HOLD_CYCLES;
        hold_seen = hold_reqs;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case (mode)
          0:       rdy = 1'b1;
          1:       rdy = 1'($urandom_range(0, 1));
          2:       rdy = ($urandom_range(0, 3) == 0);
          default: rdy = (rcv_cycle % 4) < 2;
        endcase
      end
      m_axis_tready <= rdy;
    end
  end

  // Offer one item and return at the edge that accepts it; tvalid stays high.
  task automatic send_item(logic req_type, logic [IDX_W-1:0] idx, logic [7:0] levels);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req_type;
    s_axis_tdata  <= {5'b0, levels, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(req_type, idx, levels);
  endtask

  // Stop offering, wait for every owed report, then let a trailing sweep finish.
  task automatic drain_inputs();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.outstanding() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // only called with the block idle
  task automatic write_cfg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.write_reg(addr, data);
    @(posedge clk_i);
  endtask

  // Random traffic in bursts: bouncing edges mixed with ticks whose pin levels
  // drift. Past quiet_after only ticks go out, so long timeouts can expire.
  task automatic run_random(int count, int edge_pct, int quiet_after);
    int               k;
    int               burst;
    int unsigned      action;
    logic             rt;
    logic [IDX_W-1:0] bi;
    logic [7:0]       lv;
    k  = 0;
    bi = '0;
    lv = 8'($urandom_range(0, 255));
    while (k < count) begin
      burst = $urandom_range(1, 12);
      for (int j = 0; j < burst && k < count; j++) begin
        rt = (k < quiet_after && $urandom_range(0, 99) < edge_pct) ? REQ_EDGE : REQ_TICK;
        if ($urandom_range(0, 9) >= 3) bi = IDX_W'($urandom_range(0, 7));   // else bounce again
        if ($urandom_range(0, 9) < 7) lv[3'($urandom_range(0, 7))] = 1'($urandom_range(0, 1));
        else lv = 8'($urandom_range(0, 255));
        send_item(rt, bi, lv);
        k++;
      end
      action = $urandom_range(0, 39);
      if (k >= count || action == 0) begin
        drain_inputs();
      end else if (action > 13) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_EDGE;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = REG_ENABLE_MASK;
    cfg_wdata_i   = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed. Reset config: nothing registered, so the edge is dropped and
    // the tick finds nothing due.
    send_item(REQ_EDGE, 3'd2, 8'h00);
    send_item(REQ_TICK, 3'd0, 8'hA5);
    drain_inputs();
    write_cfg(REG_ENABLE_MASK, 8'hFF);
    write_cfg(REG_TIMEOUT_TICKS, 8'd1);
    // all buttons pressed from no prior state: eight reports
    for (int i = 0; i < 8; i++) send_item(REQ_EDGE, i[2:0], 8'h00);
    send_item(REQ_TICK, 3'd7, 8'hFF);
    // pressed again: each button owes a missed release first, sixteen reports
    for (int i = 0; i < 8; i++) send_item(REQ_EDGE, 3'(7 - i), 8'h00);
    send_item(REQ_TICK, 3'd0, 8'hFF);
    // two releases in index order, then a tick with nothing due
    send_item(REQ_EDGE, 3'd7, 8'hFF);
    send_item(REQ_EDGE, 3'd3, 8'hFF);
    send_item(REQ_TICK, 3'd5, 8'h00);
    send_item(REQ_TICK, 3'd1, 8'h00);
    drain_inputs();

    // Random phases. The first starts under a long receiver hold-off so the
    // output backs up and the input stalls.
    write_cfg(REG_TIMEOUT_TICKS, 8'd3);
    hold_reqs++;
    run_random(60, 35, 60);
    // half the buttons dropped while some are still armed
    write_cfg(REG_ENABLE_MASK, 8'h5A);
    write_cfg(REG_TIMEOUT_TICKS, 8'd2);
    run_random(40, 30, 40);
    write_cfg(REG_ENABLE_MASK, 8'h00);
    run_random(20, 40, 20);
    write_cfg(REG_ENABLE_MASK, 8'hFF);
    write_cfg(REG_TIMEOUT_TICKS, 8'd1);
    run_random(36, 40, 36);
    // zero timeout counts 256 ticks
    write_cfg(REG_TIMEOUT_TICKS, 8'd0);
    run_random(264, 50, 6);
    write_cfg(REG_ENABLE_MASK, 8'h81);
    write_cfg(REG_TIMEOUT_TICKS, 8'd4);
    run_random(16, 30, 16);

    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> filelist.f
rtl/mbd_pkg.sv
rtl/mbd_cell.sv
rtl/multi_button_debouncer_top.sv
test/tb_multi_button_debouncer_top.sv
